/* hdl/pbrle_pkg.sv */
package pbrle_pkg;

    // token mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    localparam int ADDR_W      = 13;
    localparam int MAX_RES     = 4;     // most words one raw byte can cause
    localparam int QUEUE_DEPTH = 8;     // power of two, at least MAX_RES
    localparam logic [7:0] TOKEN_MAX = 8'd128;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] out_addr;
        logic [7:0]        out_byte;
        logic              end_of_item;
        logic              line_done;
        logic [ADDR_W-1:0] line_length;
    } out_word_t;

    // words produced by one raw byte, entry 0 first
    typedef struct packed {
        logic [2:0]                  n;
        out_word_t [MAX_RES-1:0]     ent;
    } push_t;

endpackage

/* hdl/pbrle_encode.sv */
module pbrle_encode
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  pbrle_pkg::in_word_t  raw,
    output pbrle_pkg::push_t     push
);

    logic [7:0]                   held_byte_reg, held_byte_next;
    logic                         held_valid_reg, held_valid_next;
    logic [1:0]                   token_mode_reg, token_mode_next;
    logic [7:0]                   token_count_reg, token_count_next;
    logic [pbrle_pkg::ADDR_W-1:0] count_slot_addr_reg, count_slot_addr_next;
    logic [pbrle_pkg::ADDR_W-1:0] next_out_addr_reg, next_out_addr_next;

    logic [7:0]                   b;
    logic                         last;
    logic [7:0]                   hb;
    logic                         hv;
    logic [1:0]                   md;
    logic [7:0]                   cnt;
    logic [pbrle_pkg::ADDR_W-1:0] slot;
    logic [pbrle_pkg::ADDR_W-1:0] na;
    logic [2:0]                   k;
    logic [pbrle_pkg::ADDR_W-1:0] ra [pbrle_pkg::MAX_RES];
    logic [7:0]                   rb [pbrle_pkg::MAX_RES];

    assign b    = raw.data_byte;
    assign last = raw.last_byte;

    always_comb
    begin
        hb   = held_byte_reg;
        hv   = held_valid_reg;
        md   = token_mode_reg;
        cnt  = token_count_reg;
        slot = count_slot_addr_reg;
        na   = next_out_addr_reg;
        k    = 3'd0;
        for (int i = 0; i < pbrle_pkg::MAX_RES; i++)
        begin
            ra[i] = '0;
            rb[i] = '0;
        end

        case (md)
            pbrle_pkg::MODE_LIT:
            begin
                if (hb != b)
                begin
                    ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1; na = na + 1'b1;
                    cnt = cnt + 8'd1;
                    if (cnt >= pbrle_pkg::TOKEN_MAX)
                    begin
                        // full literal: close it, b seeds a fresh token
                        ra[k[1:0]] = slot; rb[k[1:0]] = cnt - 8'd1; k = k + 3'd1;
                        md  = pbrle_pkg::MODE_IDLE;
                        cnt = 8'd0;
                        if (last)
                        begin
                            ra[k[1:0]] = na; rb[k[1:0]] = 8'd0; k = k + 3'd1;
                            na = na + 1'b1;
                            ra[k[1:0]] = na; rb[k[1:0]] = b; k = k + 3'd1;
                            na = na + 1'b1;
                            hv = 1'b0;
                        end
                        else
                        begin
                            hb = b;
                            hv = 1'b1;
                        end
                    end
                    else
                    begin
                        hb = b;
                        if (last)
                        begin
                            ra[k[1:0]] = na; rb[k[1:0]] = b; k = k + 3'd1;
                            na = na + 1'b1;
                            cnt = cnt + 8'd1;
                            ra[k[1:0]] = slot; rb[k[1:0]] = cnt - 8'd1; k = k + 3'd1;
                        end
                    end
                end
                else
                begin
                    // pair found: close literal, pair becomes a run
                    ra[k[1:0]] = slot; rb[k[1:0]] = cnt - 8'd1; k = k + 3'd1;
                    md  = pbrle_pkg::MODE_RUN;
                    cnt = 8'd2;
                    hv  = 1'b1;
                    if (last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = 8'd1 - cnt; k = k + 3'd1;
                        na = na + 1'b1;
                        ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1;
                        na = na + 1'b1;
                    end
                end
            end
            pbrle_pkg::MODE_RUN:
            begin
                if (b == hb)
                begin
                    cnt = cnt + 8'd1;
                    if ((cnt >= pbrle_pkg::TOKEN_MAX) || last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = 8'd1 - cnt; k = k + 3'd1;
                        na = na + 1'b1;
                        ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1;
                        na = na + 1'b1;
                        md  = pbrle_pkg::MODE_IDLE;
                        cnt = 8'd0;
                        hv  = 1'b0;
                    end
                end
                else
                begin
                    ra[k[1:0]] = na; rb[k[1:0]] = 8'd1 - cnt; k = k + 3'd1;
                    na = na + 1'b1;
                    ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1;
                    na = na + 1'b1;
                    md  = pbrle_pkg::MODE_IDLE;
                    cnt = 8'd0;
                    if (last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = 8'd0; k = k + 3'd1;
                        na = na + 1'b1;
                        ra[k[1:0]] = na; rb[k[1:0]] = b; k = k + 3'd1;
                        na = na + 1'b1;
                        hv = 1'b0;
                    end
                    else
                    begin
                        hb = b;
                        hv = 1'b1;
                    end
                end
            end
            default:
            begin
                // idle, and the unused code
                md = pbrle_pkg::MODE_IDLE;
                if (!hv)
                begin
                    cnt = 8'd0;
                    if (last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = 8'd0; k = k + 3'd1;
                        na = na + 1'b1;
                        ra[k[1:0]] = na; rb[k[1:0]] = b; k = k + 3'd1;
                        na = na + 1'b1;
                        hv = 1'b0;
                    end
                    else
                    begin
                        hb = b;
                        hv = 1'b1;
                    end
                end
                else if (b == hb)
                begin
                    md  = pbrle_pkg::MODE_RUN;
                    cnt = 8'd2;
                    if (last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = 8'd1 - cnt; k = k + 3'd1;
                        na = na + 1'b1;
                        ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1;
                        na = na + 1'b1;
                    end
                end
                else
                begin
                    // open literal: reserve count slot
                    slot = na;
                    na   = na + 1'b1;
                    ra[k[1:0]] = na; rb[k[1:0]] = hb; k = k + 3'd1; na = na + 1'b1;
                    cnt = 8'd1;
                    md  = pbrle_pkg::MODE_LIT;
                    hb  = b;
                    hv  = 1'b1;
                    if (last)
                    begin
                        ra[k[1:0]] = na; rb[k[1:0]] = b; k = k + 3'd1;
                        na = na + 1'b1;
                        cnt = cnt + 8'd1;
                        ra[k[1:0]] = slot; rb[k[1:0]] = cnt - 8'd1; k = k + 3'd1;
                    end
                end
            end
        endcase

        for (int i = 0; i < pbrle_pkg::MAX_RES; i++)
        begin
            push.ent[i].out_addr    = ra[i];
            push.ent[i].out_byte    = rb[i];
            push.ent[i].end_of_item = (k == 3'(i + 1));
            push.ent[i].line_done   = last && (k == 3'(i + 1));
            push.ent[i].line_length = (last && (k == 3'(i + 1))) ? na : '0;
        end
        push.n = take ? k : 3'd0;

        if (last)
        begin
            held_byte_next       = '0;
            held_valid_next      = 1'b0;
            token_mode_next      = pbrle_pkg::MODE_IDLE;
            token_count_next     = '0;
            count_slot_addr_next = '0;
            next_out_addr_next   = '0;
        end
        else
        begin
            held_byte_next       = hb;
            held_valid_next      = hv;
            token_mode_next      = md;
            token_count_next     = cnt;
            count_slot_addr_next = slot;
            next_out_addr_next   = na;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg       <= '0;
            held_valid_reg      <= 1'b0;
            token_mode_reg      <= pbrle_pkg::MODE_IDLE;
            token_count_reg     <= '0;
            count_slot_addr_reg <= '0;
            next_out_addr_reg   <= '0;
        end
        else if (take)
        begin
            held_byte_reg       <= held_byte_next;
            held_valid_reg      <= held_valid_next;
            token_mode_reg      <= token_mode_next;
            token_count_reg     <= token_count_next;
            count_slot_addr_reg <= count_slot_addr_next;
            next_out_addr_reg   <= next_out_addr_next;
        end
    end

endmodule

/* hdl/pbrle_queue.sv */
module pbrle_queue
#(
    parameter int DEPTH = pbrle_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbrle_pkg::push_t     push,
    output logic                 full,
    output logic                 enc_valid,
    input  logic                 enc_stall,
    output pbrle_pkg::out_word_t enc
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - pbrle_pkg::MAX_RES);

    pbrle_pkg::out_word_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign enc_valid = (count_reg != '0);
    assign enc       = mem[rd_ptr_reg];
    assign pop       = enc_valid && !enc_stall;
    // leave room for a worst-case burst from the next byte
    assign full      = (count_reg > ROOM_LIMIT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pbrle_pkg::MAX_RES; i++)
        begin
            if (3'(i) < push.n)
            begin
                mem[wr_ptr_reg + PW'(i)] <= push.ent[i];
            end
        end
    end

endmodule

/* hdl/packbits_rle_line_encoder.sv */
// PackBits line encoder. Raw raster bytes enter on raw (last_byte on the
// line's final byte); encoded bytes leave on enc, each with its address in
// the encoded line buffer, since a literal's count byte is written after its
// data once the literal closes. The encoder accepts one raw byte every cycle
// while raw_stall is low: all token work for a byte is one pass of logic
// between the token state registers and a result queue. A byte yields 0 to 4
// encoded words, which are written into the queue (QUEUE_DEPTH words) and
// reach enc from there, one per cycle while enc_stall is low. raw_stall rises
// only while the queue holds more than QUEUE_DEPTH - 4 words, so with enc_stall
// low a stream averaging at most one word per byte runs at one byte per cycle.
// The word with line_done set carries the line's encoded length, and the next
// line starts again at address 0. Addresses wrap at 8192.
module packbits_rle_line_encoder
#(
    parameter int QUEUE_DEPTH = pbrle_pkg::QUEUE_DEPTH  // power of two, >= 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 raw_valid,
    output logic                 raw_stall,
    input  pbrle_pkg::in_word_t  raw,
    output logic                 enc_valid,
    input  logic                 enc_stall,
    output pbrle_pkg::out_word_t enc
);

    logic             take;    // raw byte accepted this edge
    logic             full;    // queue lacks room for a worst-case burst
    pbrle_pkg::push_t push;    // encoded words from this byte

    assign raw_stall = full;
    assign take      = raw_valid && !full;

    // token state and per-byte encode
    pbrle_encode u_encode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .raw   (raw),
        .push  (push)
    );

    // result queue, multi-word write, one word read
    pbrle_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc       (enc)
    );

endmodule

/* hdl/pbrle_check.sv */
module pbrle_check
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 raw_stall,
    input logic                 enc_valid,
    input logic                 enc_stall,
    input pbrle_pkg::out_word_t enc
);

    // a waiting encoded word stays offered
    a_enc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_stall |=> enc_valid)
        else $error("encoded word dropped while stalled");

    // a waiting encoded word does not change
    a_enc_stable: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_stall |=> $stable(enc))
        else $error("encoded word changed while stalled");

    // line end is always the last word of its byte
    a_done_eoi: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc.line_done |-> enc.end_of_item)
        else $error("line_done without end_of_item");

    // length only reported with line end
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && !enc.line_done |-> enc.line_length == '0)
        else $error("line_length set off line end");

    // raw side only held off while encoded words are waiting
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        raw_stall |-> enc_valid)
        else $error("raw_stall with nothing to drain");

endmodule

bind packbits_rle_line_encoder pbrle_check u_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .raw_stall (raw_stall),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc       (enc)
);

/* bench/tb_packbits_rle_line_encoder.sv */
`timescale 1ns / 100ps

module tb_packbits_rle_line_encoder;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 raw_valid = 1'b0;
    logic                 raw_stall;
    pbrle_pkg::in_word_t  raw       = '0;
    logic                 enc_valid;
    logic                 enc_stall = 1'b0;
    pbrle_pkg::out_word_t enc;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    packbits_rle_line_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw       (raw),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc       (enc)
    );

    // ------------------------------------------------------------------
    // Run bookkeeping
    // ------------------------------------------------------------------
    pbrle_pkg::out_word_t pending_enc_words [$];  // encoded words still owed by the DUT
    logic [7:0] line_bytes [$];         // raw line being assembled by a test
    int         errors         = 0;
    int         bytes_sent     = 0;
    int         lines_sent     = 0;
    int         words_checked  = 0;
    int         raw_held_off   = 0;     // cycles the encoder pushed back on raw
    bit         src_idling     = 1'b1;
    bit         sink_idling    = 1'b1;
    int         long_hold_cycles = 0;   // one-shot request for a long enc_stall

    // ------------------------------------------------------------------
    // Line encoder model: token state plus the words of the current byte
    // ------------------------------------------------------------------
    logic [7:0]                   held_byte_m;     // pending literal byte / run byte
    logic                         held_ok;
    logic [1:0]                   mode_m;
    logic [7:0]                   tok_len;
    logic [pbrle_pkg::ADDR_W-1:0] slot_addr;       // reserved count slot of open literal
    logic [pbrle_pkg::ADDR_W-1:0] wr_addr;         // next free encoded address
    pbrle_pkg::out_word_t         step_words [pbrle_pkg::MAX_RES];
    int                           step_n;

    task automatic clear_encoder();
        held_byte_m = '0;
        held_ok     = 1'b0;
        mode_m      = pbrle_pkg::MODE_IDLE;
        tok_len     = '0;
        slot_addr   = '0;
        wr_addr     = '0;
    endtask

    task automatic put_at(input logic [pbrle_pkg::ADDR_W-1:0] a, input logic [7:0] b);
        if (step_n < pbrle_pkg::MAX_RES)
        begin
            step_words[step_n] = '{out_addr: a, out_byte: b, end_of_item: 1'b0,
                                   line_done: 1'b0, line_length: '0};
            step_n++;
        end
    endtask

    task automatic put_next(input logic [7:0] b);
        put_at(wr_addr, b);
        wr_addr = wr_addr + 1'b1;
    endtask

    task automatic close_lit();
        put_at(slot_addr, tok_len - 8'd1);
    endtask

    // repeat count is 257 - n, i.e. 1 - n mod 256
    task automatic put_run();
        put_next(8'd1 - tok_len);
        put_next(held_byte_m);
    endtask

    // new decision window; a lone last byte goes out as a 1-byte literal
    task automatic start_token(input logic [7:0] b, input logic last);
        mode_m  = pbrle_pkg::MODE_IDLE;
        tok_len = '0;
        if (last)
        begin
            put_next(8'd0);
            put_next(b);
            held_ok = 1'b0;
        end
        else
        begin
            held_byte_m = b;
            held_ok     = 1'b1;
        end
    endtask

    task automatic encode_byte(input pbrle_pkg::in_word_t w);
        logic [7:0] b;
        logic       last;
        logic [1:0] m;
        int         i;
        b      = w.data_byte;
        last   = w.last_byte;
        step_n = 0;
        // unused mode code falls back to idle
        m = (mode_m == pbrle_pkg::MODE_LIT || mode_m == pbrle_pkg::MODE_RUN) ?
            mode_m : pbrle_pkg::MODE_IDLE;
        if (m == pbrle_pkg::MODE_IDLE)
        begin
            if (!held_ok)
                start_token(b, last);
            else if (b == held_byte_m)
            begin
                mode_m  = pbrle_pkg::MODE_RUN;
                tok_len = 8'd2;
                if (last)
                    put_run();
            end
            else
            begin
                slot_addr = wr_addr;            // reserve the count slot
                wr_addr   = wr_addr + 1'b1;
                put_next(held_byte_m);
                tok_len     = 8'd1;
                mode_m      = pbrle_pkg::MODE_LIT;
                held_byte_m = b;
                held_ok     = 1'b1;
                if (last)
                begin
                    put_next(b);
                    tok_len++;
                    close_lit();
                end
            end
        end
        else if (m == pbrle_pkg::MODE_LIT)
        begin
            if (held_byte_m != b)
            begin
                put_next(held_byte_m);
                tok_len++;
                if (tok_len >= pbrle_pkg::TOKEN_MAX)
                begin
                    close_lit();
                    start_token(b, last);
                end
                else
                begin
                    held_byte_m = b;
                    if (last)
                    begin
                        put_next(b);
                        tok_len++;
                        close_lit();
                    end
                end
            end
            else
            begin
                // pending byte repeats: literal closes, a run of two opens
                close_lit();
                mode_m  = pbrle_pkg::MODE_RUN;
                tok_len = 8'd2;
                held_ok = 1'b1;
                if (last)
                    put_run();
            end
        end
        else
        begin
            if (b == held_byte_m)
            begin
                tok_len++;
                if (tok_len >= pbrle_pkg::TOKEN_MAX || last)
                begin
                    put_run();
                    mode_m  = pbrle_pkg::MODE_IDLE;
                    tok_len = '0;
                    held_ok = 1'b0;
                end
            end
            else
            begin
                put_run();
                start_token(b, last);
            end
        end

        if (step_n > 0)
        begin
            step_words[step_n-1].end_of_item = 1'b1;
            if (last)
            begin
                step_words[step_n-1].line_done   = 1'b1;
                step_words[step_n-1].line_length = wr_addr;
            end
        end
        for (i = 0; i < step_n; i++)
            pending_enc_words.push_back(step_words[i]);
        if (last)
            clear_encoder();
    endtask

    // ------------------------------------------------------------------
    // Raw side driver: one word, held until taken, then maybe a gap
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        pbrle_pkg::in_word_t w;
        int                  gap;
        w.data_byte = b;
        w.last_byte = last;
        @(negedge clk);
        raw_valid <= 1'b1;
        raw       <= w;
        @(posedge clk);
        while (raw_stall !== 1'b0)
            @(posedge clk);
        encode_byte(w);
        bytes_sent++;
        if (src_idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            raw_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
        lines_sent++;
    endtask

    // line builders; literal bytes always differ from the byte before them
    task automatic add_run(input logic [7:0] b, input int n);
        repeat (n) line_bytes.push_back(b);
    endtask

    task automatic add_literal(input int n);
        logic [7:0] prev;
        prev = (line_bytes.size() != 0) ? line_bytes[$] : 8'($urandom);
        repeat (n)
        begin
            prev = prev ^ 8'($urandom_range(1, 255));
            line_bytes.push_back(prev);
        end
    endtask

    // two-symbol noise: short runs and literals mixed at random
    task automatic add_noise(input int n);
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        sym_a = 8'($urandom);
        sym_b = sym_a ^ (8'd1 << $urandom_range(0, 7));
        repeat (n) line_bytes.push_back($urandom_range(0, 1) ? sym_a : sym_b);
    endtask

    // ------------------------------------------------------------------
    // Encoded side: stall pacing and the scoreboard
    // ------------------------------------------------------------------
    initial
    begin : enc_pacing
        int n;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles != 0)
            begin
                enc_stall <= 1'b1;
                repeat (long_hold_cycles) @(negedge clk);
                long_hold_cycles = 0;
                enc_stall <= 1'b0;
            end
            else if (sink_idling && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 8);
                enc_stall <= 1'b1;
                repeat (n) @(negedge clk);
                enc_stall <= 1'b0;
            end
        end
    end

    task automatic flag_error(input string what, input pbrle_pkg::out_word_t want,
                              input pbrle_pkg::out_word_t got);
        errors++;
        if (errors <= 10)
            $display("ERROR %s at %0t: expected addr=%0d byte=%02h eoi=%b done=%b len=%0d",
                     what, $realtime, want.out_addr, want.out_byte, want.end_of_item,
                     want.line_done, want.line_length);
        if (errors <= 10)
            $display("      got      addr=%0d byte=%02h eoi=%b done=%b len=%0d",
                     got.out_addr, got.out_byte, got.end_of_item, got.line_done,
                     got.line_length);
    endtask

    always @(posedge clk)
    begin : enc_check
        pbrle_pkg::out_word_t want;
        if (rst_n === 1'b1 && raw_valid === 1'b1 && raw_stall === 1'b1)
            raw_held_off++;
        if (rst_n === 1'b1 && enc_valid === 1'b1 && enc_stall === 1'b0)
        begin
            words_checked++;
            if (pending_enc_words.size() == 0)
                flag_error("unexpected word", '0, enc);
            else
            begin
                want = pending_enc_words.pop_front();
                if (enc.out_addr !== want.out_addr || enc.out_byte !== want.out_byte
                    || enc.end_of_item !== want.end_of_item
                    || enc.line_done !== want.line_done
                    || enc.line_length !== want.line_length)
                    flag_error("word mismatch", want, enc);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // short hand-made lines: lone bytes, pairs, literal into run, run into
    // a lone tail, all-ones/all-zeros/alternating data bits
    task automatic test_directed_tokens();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h30, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        lines_sent += 8;
    endtask

    // short random lines built from runs, literals and noise
    task automatic test_random_lines(input int byte_goal);
        int start;
        int segs;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal)
        begin
            segs = $urandom_range(1, 4);
            repeat (segs)
            begin
                case ($urandom_range(0, 3))
                    0: add_run(8'($urandom), $urandom_range(1, 8));
                    1: add_literal($urandom_range(1, 8));
                    2: add_noise($urandom_range(1, 10));
                    default: add_run(8'($urandom), $urandom_range(2, 3));
                endcase
            end
            send_line();
        end
    endtask

    // runs and literals at and just past the 128-byte token limit
    task automatic test_full_tokens();
        add_run(8'($urandom), 128 + $urandom_range(0, 3));
        add_literal(128 + $urandom_range(0, 3));
        add_run(8'($urandom), 2);
        send_line();
    endtask

    // encoded side frozen for a long stretch while raw words keep coming,
    // so the result queue fills and raw_stall must hold the sender off
    task automatic test_backpressure();
        src_idling       = 1'b0;
        long_hold_cycles = 150;
        add_literal(40);
        send_line();
        src_idling = 1'b1;
    endtask

    // closing stretch at full rate on both sides
    task automatic test_streaming();
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        test_random_lines(40);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int guard;
        clear_encoder();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_tokens();
        test_random_lines(100);
        test_full_tokens();
        test_backpressure();
        test_streaming();

        @(negedge clk);
        raw_valid <= 1'b0;

        guard = 0;
        while (pending_enc_words.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);   // catch any stray trailing word
        if (pending_enc_words.size() != 0)
        begin
            $display("ERROR %0d expected words never arrived", pending_enc_words.size());
            errors += pending_enc_words.size();
        end

        $display("Covered %0d raw bytes in %0d lines, %0d encoded words checked,",
                 bytes_sent, lines_sent, words_checked);
        $display("full-size tokens and %0d cycles of raw backpressure.",
                 raw_held_off);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
